>>> rtl/cbc_pkg.sv
// Package for the chunk reference bitmap classifier.
// Holds store sizes, opcodes, payload structs, controller states and command/status types.
// Depends on nothing.
package cbc_pkg;

	localparam int CHUNK_COUNT     = 65536;
	localparam int CONTAINER_COUNT = 4096;

	localparam int WORD_COUNT = (CHUNK_COUNT + 31) / 32;
	localparam int WORD_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int CONT_W     = $clog2(CONTAINER_COUNT);
	localparam int CLR_COUNT  = (WORD_COUNT > CONTAINER_COUNT) ? WORD_COUNT : CONTAINER_COUNT;
	localparam int CLR_W      = $clog2(CLR_COUNT);

	localparam logic [2:0] OP_MARK     = 3'd0;
	localparam logic [2:0] OP_TEST     = 3'd1;
	localparam logic [2:0] OP_CLASSIFY = 3'd2;
	localparam logic [2:0] OP_NEW      = 3'd3;
	localparam logic [2:0] OP_READ     = 3'd4;

	localparam logic [1:0] CLS_CLEAR = 2'd0;
	localparam logic [1:0] CLS_MIXED = 2'd1;
	localparam logic [1:0] CLS_SET   = 2'd2;

	localparam logic [1:0] CODE_PARTIAL = 2'b10;
	localparam logic [1:0] CODE_FULL    = 2'b11;
	localparam logic [1:0] CODE_NEW     = 2'b01;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [16:0] chunk_number;
		logic [16:0] last_chunk;
		logic [11:0] container_index;
	} req_t;

	typedef struct packed {
		logic       chunk_bit;
		logic [1:0] range_class;
		logic [1:0] container_code;
		logic       bad_request;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_EXEC,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clr_wr;
		logic chk;
		logic exec;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic bad;
		logic exec_done;
		logic out_free;
	} sts_t;

endpackage

>>> rtl/cbc_ctrl.sv
// Controller state machine for the chunk reference bitmap classifier.
// Sequences clearing, request check, execution/scan and result hand-off.
// Depends on cbc_pkg.
module cbc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cbc_pkg::sts_t sts,
	output cbc_pkg::cmd_t cmd
);

	cbc_pkg::state_t state_q;
	cbc_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cbc_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cbc_pkg::ST_CLEAR: begin
				if (sts.clr_last) state_d = cbc_pkg::ST_IDLE;
			end
			cbc_pkg::ST_IDLE: begin
				if (req_valid) state_d = cbc_pkg::ST_CHECK;
			end
			cbc_pkg::ST_CHECK: begin
				state_d = sts.bad ? cbc_pkg::ST_DONE : cbc_pkg::ST_EXEC;
			end
			cbc_pkg::ST_EXEC: begin
				if (sts.exec_done) state_d = cbc_pkg::ST_DONE;
			end
			cbc_pkg::ST_DONE: begin
				if (sts.out_free) state_d = cbc_pkg::ST_IDLE;
			end
			default: state_d = cbc_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		req_ready    = (state_q == cbc_pkg::ST_IDLE);
		cmd.capture  = (state_q == cbc_pkg::ST_IDLE) && req_valid;
		cmd.clr_wr   = (state_q == cbc_pkg::ST_CLEAR);
		cmd.chk      = (state_q == cbc_pkg::ST_CHECK);
		cmd.exec     = (state_q == cbc_pkg::ST_EXEC);
		cmd.out_load = (state_q == cbc_pkg::ST_DONE) && sts.out_free;
	end

endmodule

>>> rtl/cbc_dpath.sv
// Datapath for the chunk reference bitmap classifier.
// Holds the bitmap and container code memories, the range scan and the result register.
// Depends on cbc_pkg.
module cbc_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  cbc_pkg::cmd_t cmd,
	output cbc_pkg::sts_t sts,
	input  cbc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cbc_pkg::rsp_t rsp
);

	logic [31:0] bmem [cbc_pkg::WORD_COUNT];
	logic [1:0]  cmem [cbc_pkg::CONTAINER_COUNT];

	cbc_pkg::req_t             req_q;
	cbc_pkg::rsp_t             res_q;
	cbc_pkg::rsp_t             rsp_q;
	logic                      rsp_valid_q;
	logic [cbc_pkg::CLR_W-1:0] clr_q;
	logic [cbc_pkg::WORD_W-1:0] cur_q;
	logic [31:0]               bm_rd_q;
	logic [1:0]                cd_rd_q;
	logic                      any_set_q;
	logic                      any_clear_q;

	logic [31:0]                f32, l32, c32;
	logic                       first_ok, last_ok, cont_ok, bad;
	logic [cbc_pkg::WORD_W-1:0] first_word, last_word, bm_raddr;
	logic [4:0]                 first_bit, last_bit, lo, hi;
	logic [31:0]                mask;
	logic                       any_set_n, any_clear_n, both_n, done;
	logic [1:0]                 cls, new_code;
	logic [cbc_pkg::CONT_W-1:0] cidx;
	cbc_pkg::rsp_t              res_n;

	always_comb begin
		f32        = 32'(req_q.chunk_number) - 32'd1;
		l32        = 32'(req_q.last_chunk) - 32'd1;
		c32        = 32'(req_q.container_index);
		first_ok   = (req_q.chunk_number != '0) &&
			(32'(req_q.chunk_number) <= 32'(cbc_pkg::CHUNK_COUNT));
		last_ok    = (req_q.last_chunk != '0) &&
			(32'(req_q.last_chunk) <= 32'(cbc_pkg::CHUNK_COUNT));
		cont_ok    = c32 < 32'(cbc_pkg::CONTAINER_COUNT);
		cidx       = c32[cbc_pkg::CONT_W-1:0];
		first_word = f32[cbc_pkg::WORD_W+4:5];
		last_word  = l32[cbc_pkg::WORD_W+4:5];
		first_bit  = f32[4:0];
		last_bit   = l32[4:0];
		unique case (req_q.opcode)
			cbc_pkg::OP_MARK, cbc_pkg::OP_TEST: bad = !first_ok;
			cbc_pkg::OP_CLASSIFY: bad = !first_ok || !last_ok || !cont_ok ||
				(req_q.chunk_number > req_q.last_chunk);
			cbc_pkg::OP_NEW, cbc_pkg::OP_READ: bad = !cont_ok;
			default: bad = 1'b1;
		endcase
	end

	always_comb begin
		lo          = (cur_q == first_word) ? first_bit : 5'd0;
		hi          = (cur_q == last_word) ? last_bit : 5'd31;
		mask        = (32'hFFFF_FFFF << lo) & (32'hFFFF_FFFF >> (5'd31 - hi));
		any_set_n   = any_set_q | (|(bm_rd_q & mask));
		any_clear_n = any_clear_q | (|(~bm_rd_q & mask));
		both_n      = any_set_n && any_clear_n;
		if (both_n) begin
			cls      = cbc_pkg::CLS_MIXED;
			new_code = cd_rd_q | cbc_pkg::CODE_PARTIAL;
		end else if (any_set_n) begin
			cls      = cbc_pkg::CLS_SET;
			new_code = cd_rd_q | cbc_pkg::CODE_FULL;
		end else begin
			cls      = cbc_pkg::CLS_CLEAR;
			new_code = cd_rd_q;
		end
		if (req_q.opcode == cbc_pkg::OP_CLASSIFY) begin
			done = (cur_q == last_word) || both_n;
		end else begin
			done = 1'b1;
		end
		bm_raddr = cmd.chk ? first_word : cur_q + 1'b1;
	end

	always_comb begin
		res_n = '0;
		unique case (req_q.opcode)
			cbc_pkg::OP_TEST:     res_n.chunk_bit = bm_rd_q[first_bit];
			cbc_pkg::OP_CLASSIFY: begin
				res_n.range_class    = cls;
				res_n.container_code = new_code;
			end
			cbc_pkg::OP_NEW:      res_n.container_code = cd_rd_q | cbc_pkg::CODE_NEW;
			cbc_pkg::OP_READ:     res_n.container_code = cd_rd_q;
			default:              res_n.chunk_bit = 1'b0;
		endcase
	end

	always_comb begin
		sts.clr_last  = (clr_q == cbc_pkg::CLR_W'(cbc_pkg::CLR_COUNT - 1));
		sts.bad       = bad;
		sts.exec_done = done;
		sts.out_free  = !rsp_valid_q || rsp_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			if (32'(clr_q) < 32'(cbc_pkg::WORD_COUNT)) begin
				bmem[clr_q[cbc_pkg::WORD_W-1:0]] <= '0;
			end
			if (32'(clr_q) < 32'(cbc_pkg::CONTAINER_COUNT)) begin
				cmem[clr_q[cbc_pkg::CONT_W-1:0]] <= '0;
			end
		end else if (cmd.exec) begin
			if (req_q.opcode == cbc_pkg::OP_MARK) begin
				bmem[cur_q] <= bm_rd_q | (32'd1 << first_bit);
			end
			if (req_q.opcode == cbc_pkg::OP_NEW) begin
				cmem[cidx] <= cd_rd_q | cbc_pkg::CODE_NEW;
			end
			if (req_q.opcode == cbc_pkg::OP_CLASSIFY && done && cls != cbc_pkg::CLS_CLEAR) begin
				cmem[cidx] <= new_code;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.chk || cmd.exec) begin
			bm_rd_q <= bmem[bm_raddr];
		end
		if (cmd.chk) begin
			cd_rd_q <= cmem[cidx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
		if (cmd.chk) begin
			cur_q       <= first_word;
			any_set_q   <= 1'b0;
			any_clear_q <= 1'b0;
			res_q       <= '{chunk_bit: 1'b0, range_class: 2'd0, container_code: 2'd0,
				bad_request: 1'b1};
		end else if (cmd.exec) begin
			cur_q       <= cur_q + 1'b1;
			any_set_q   <= any_set_n;
			any_clear_q <= any_clear_n;
			res_q       <= res_n;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

>>> rtl/chunk_reference_bitmap_classifier.sv
// Top level of the chunk reference bitmap classifier.
// Joins the controller (cbc_ctrl) and the datapath (cbc_dpath); depends on cbc_pkg.
//
//   channel | signals                   | payload
//   request | req_valid / req_ready     | req : cbc_pkg::req_t
//   result  | rsp_valid / rsp_ready     | rsp : cbc_pkg::rsp_t
//
// One request at a time. A request passes the check, execution and result states in turn (bad
// requests skip execution); classify scans one 32-bit bitmap word per step via the single read port.
// After reset a clearing pass zeroes both memories; req_ready stays low meanwhile.
// The result register lets the next request enter while a result waits on rsp_ready.
module chunk_reference_bitmap_classifier (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  cbc_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output cbc_pkg::rsp_t rsp
);

	cbc_pkg::cmd_t cmd;
	cbc_pkg::sts_t sts;

	cbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	cbc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

>>> verif/chunk_mark_checker.sv
// Checker for the chunk reference bitmap classifier: watches both channels, predicts each
// result from its own copy of the chunk bitmap and container codes, and counts mismatches.
// Depends on cbc_pkg for the payload types, opcodes and store sizes.
`timescale 1ns / 1ps

module chunk_mark_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic          req_ready,
	input  cbc_pkg::req_t req,
	input  logic          rsp_valid,
	input  logic          rsp_ready,
	input  cbc_pkg::rsp_t rsp,
	output int            mismatches,
	output int            results_due
);

	localparam int CHUNK_W = $clog2(cbc_pkg::CHUNK_COUNT);

	bit            referenced [cbc_pkg::CHUNK_COUNT];
	bit [1:0]      codes [cbc_pkg::CONTAINER_COUNT];
	cbc_pkg::rsp_t awaited_results [$];

	function automatic cbc_pkg::rsp_t resolve_request(input cbc_pkg::req_t r);
		cbc_pkg::rsp_t res;
		int   first;
		int   last;
		int   n;
		bit   first_ok;
		bit   last_ok;
		bit   cont_ok;
		bit   any_set;
		bit   any_clear;
		res = '0;
		first = int'(r.chunk_number);
		last = int'(r.last_chunk);
		first_ok = first >= 1 && first <= cbc_pkg::CHUNK_COUNT;
		last_ok = last >= 1 && last <= cbc_pkg::CHUNK_COUNT;
		cont_ok = r.container_index < cbc_pkg::CONTAINER_COUNT;
		any_set = 1'b0;
		any_clear = 1'b0;
		case (r.opcode)
			cbc_pkg::OP_MARK: begin
				if (first_ok)
					referenced[CHUNK_W'(first - 1)] = 1'b1;
				else
					res.bad_request = 1'b1;
			end
			cbc_pkg::OP_TEST: begin
				if (first_ok)
					res.chunk_bit = referenced[CHUNK_W'(first - 1)];
				else
					res.bad_request = 1'b1;
			end
			cbc_pkg::OP_CLASSIFY: begin
				if (!first_ok || !last_ok || first > last || !cont_ok) begin
					res.bad_request = 1'b1;
				end else begin
					for (n = first; n <= last && !(any_set && any_clear); n++) begin
						if (referenced[CHUNK_W'(n - 1)])
							any_set = 1'b1;
						else
							any_clear = 1'b1;
					end
					if (any_set && any_clear) begin
						res.range_class = cbc_pkg::CLS_MIXED;
						codes[r.container_index] |= cbc_pkg::CODE_PARTIAL;
					end else if (any_set) begin
						res.range_class = cbc_pkg::CLS_SET;
						codes[r.container_index] |= cbc_pkg::CODE_FULL;
					end else begin
						res.range_class = cbc_pkg::CLS_CLEAR;
					end
					res.container_code = codes[r.container_index];
				end
			end
			cbc_pkg::OP_NEW: begin
				if (cont_ok) begin
					codes[r.container_index] |= cbc_pkg::CODE_NEW;
					res.container_code = codes[r.container_index];
				end else begin
					res.bad_request = 1'b1;
				end
			end
			cbc_pkg::OP_READ: begin
				if (cont_ok)
					res.container_code = codes[r.container_index];
				else
					res.bad_request = 1'b1;
			end
			default: res.bad_request = 1'b1;
		endcase
		return res;
	endfunction

	task automatic compare_field(input string name, input logic [1:0] want,
		input logic [1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		cbc_pkg::rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result transaction with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_results.pop_front();
					compare_field("chunk_bit", 2'(want.chunk_bit), 2'(rsp.chunk_bit));
					compare_field("range_class", want.range_class, rsp.range_class);
					compare_field("container_code", want.container_code, rsp.container_code);
					compare_field("bad_request", 2'(want.bad_request), 2'(rsp.bad_request));
				end
			end
			if (req_valid && req_ready)
				awaited_results.push_back(resolve_request(req));
			results_due = awaited_results.size();
		end
	end

endmodule

>>> verif/chunk_reference_bitmap_classifier_test.sv
// Testbench top for the chunk reference bitmap classifier: drives directed and random
// requests with random idling on both channels and gives the verdict.
// Depends on cbc_pkg, the block and chunk_mark_checker.
`timescale 1ns / 1ps

module chunk_reference_bitmap_classifier_test;

	localparam int          RANDOM_ITEMS = 900;
	localparam int          HOLD_AT      = 300;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          LIMIT_CYCLES = 600000;
	localparam logic [2:0]  OP_MAX       = 3'd7;
	localparam logic [16:0] CHUNK_ALL    = 17'h1FFFF;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	cbc_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	cbc_pkg::rsp_t rsp;
	int            mismatches;
	int            results_due;
	int            sent;
	bit            calm;
	bit            pause_next;

	chunk_reference_bitmap_classifier u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	chunk_mark_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.results_due (results_due)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#(LIMIT_CYCLES * 12);
		$display("simulation failed");
		$finish;
	end

	function automatic logic [16:0] rand_chunk();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 45)
			return 17'($urandom_range(1, 600));
		if (pick < 75)
			return 17'(cbc_pkg::CHUNK_COUNT - $urandom_range(0, 600));
		if (pick < 92)
			return 17'($urandom_range(1, cbc_pkg::CHUNK_COUNT));
		if (pick < 96)
			return '0;
		return 17'($urandom_range(cbc_pkg::CHUNK_COUNT + 1, CHUNK_ALL));
	endfunction

	function automatic logic [11:0] rand_container();
		if ($urandom_range(99) < 75)
			return 12'($urandom_range(0, 15));
		return 12'($urandom_range(0, cbc_pkg::CONTAINER_COUNT - 1));
	endfunction

	task automatic drain();
		req_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	task automatic issue(input logic [2:0] op, input logic [16:0] first,
		input logic [16:0] last, input logic [11:0] cidx);
		cbc_pkg::req_t item;
		item.opcode = op;
		item.chunk_number = first;
		item.last_chunk = last;
		item.container_index = cidx;
		req <= item;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		sent++;
		if (pause_next) begin
			pause_next = 1'b0;
			drain();
		end else if (!calm && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// receiver: random back-pressure plus one long hold-off
	initial begin
		int taken;
		taken = 0;
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready)
				taken++;
			if (taken == HOLD_AT) begin
				taken++;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				rsp_ready <= calm || $urandom_range(99) >= 23;
			end
		end
	end

	initial begin
		logic [16:0] first;
		logic [16:0] last;
		int          span;
		int          pick;
		int          sel;
		int          op;
		bit          paused;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		calm = 1'b0;
		pause_next = 1'b0;
		paused = 1'b0;
		sent = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		issue(cbc_pkg::OP_TEST, 17'd1, CHUNK_ALL, '0);
		issue(cbc_pkg::OP_MARK, 17'd1, '0, '1);
		issue(cbc_pkg::OP_MARK, 17'(cbc_pkg::CHUNK_COUNT), CHUNK_ALL, '0);
		issue(cbc_pkg::OP_TEST, 17'(cbc_pkg::CHUNK_COUNT), '0, '1);
		issue(cbc_pkg::OP_MARK, '0, '0, '0);
		issue(cbc_pkg::OP_TEST, CHUNK_ALL, CHUNK_ALL, '1);
		issue(cbc_pkg::OP_MARK, 17'(cbc_pkg::CHUNK_COUNT + 1), '0, '0);
		issue(cbc_pkg::OP_CLASSIFY, 17'd1, 17'd1, '0);
		issue(cbc_pkg::OP_CLASSIFY, 17'd2, 17'd2, 12'd1);
		issue(cbc_pkg::OP_MARK, 17'd32, '0, '0);
		issue(cbc_pkg::OP_MARK, 17'd33, '0, '0);
		issue(cbc_pkg::OP_CLASSIFY, 17'd32, 17'd33, '1);
		issue(cbc_pkg::OP_CLASSIFY, 17'd1, 17'd40, 12'd2);
		issue(cbc_pkg::OP_CLASSIFY, 17'd40, 17'd1, 12'd3);
		issue(cbc_pkg::OP_CLASSIFY, '0, 17'd5, 12'd3);
		issue(cbc_pkg::OP_CLASSIFY, 17'd5, CHUNK_ALL, 12'd3);
		issue(cbc_pkg::OP_CLASSIFY, 17'd1, 17'(cbc_pkg::CHUNK_COUNT), 12'd6);
		issue(cbc_pkg::OP_CLASSIFY, 17'(cbc_pkg::CHUNK_COUNT - 100),
			17'(cbc_pkg::CHUNK_COUNT - 1), 12'd7);
		issue(cbc_pkg::OP_NEW, '0, '0, 12'd5);
		issue(cbc_pkg::OP_NEW, CHUNK_ALL, CHUNK_ALL, '1);
		issue(cbc_pkg::OP_READ, '0, '0, 12'd5);
		issue(cbc_pkg::OP_READ, '0, '0, 12'd2);
		for (op = cbc_pkg::OP_READ + 1; op <= OP_MAX; op++)
			issue(3'(op), 17'($urandom), 17'($urandom), 12'($urandom));
		drain();

		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			calm = sent >= 250 && sent < 420;
			if (sent >= RANDOM_ITEMS / 2 && !paused) begin
				paused = 1'b1;
				pause_next = 1'b1;
			end
			first = rand_chunk();
			pick = $urandom_range(99);
			if (pick < 4) begin
				// mark a run of chunks, then classify around it
				span = $urandom_range(0, 32);
				for (int i = 0; i <= span; i++)
					issue(cbc_pkg::OP_MARK, 17'(first + i), 17'($urandom), rand_container());
				issue(cbc_pkg::OP_CLASSIFY, 17'(first - $urandom_range(0, 2)),
					17'(first + span + $urandom_range(0, 2)), rand_container());
			end else if (pick < 28) begin
				issue(cbc_pkg::OP_MARK, first, 17'($urandom), rand_container());
			end else if (pick < 46) begin
				issue(cbc_pkg::OP_TEST, first, 17'($urandom), rand_container());
			end else if (pick < 76) begin
				sel = $urandom_range(99);
				if (sel < 80)
					last = 17'(first + $urandom_range(0, 150));
				else if (sel < 88)
					last = 17'(first - $urandom_range(1, 40));
				else if (sel < 92)
					last = 17'(first + $urandom_range(1000, cbc_pkg::CHUNK_COUNT));
				else
					last = rand_chunk();
				issue(cbc_pkg::OP_CLASSIFY, first, last, rand_container());
			end else if (pick < 86) begin
				issue(cbc_pkg::OP_NEW, 17'($urandom), 17'($urandom), rand_container());
			end else if (pick < 96) begin
				issue(cbc_pkg::OP_READ, 17'($urandom), 17'($urandom), rand_container());
			end else begin
				issue(3'($urandom_range(cbc_pkg::OP_READ + 1, OP_MAX)), 17'($urandom),
					17'($urandom), 12'($urandom));
			end
		end
		calm = 1'b0;
		drain();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && results_due == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
